FILE: rtl/ismu_pkg.sv
// shared types and constants for the ising metropolis spin update unit
// no dependencies; imported by ismu_decide, the top level and the testbench files
`default_nettype none

package ismu_pkg;

	// lattice geometry
	localparam int SIDE     = 16;
	localparam int SITES    = SIDE * SIDE;
	localparam int COORD_W  = $clog2(SIDE);
	localparam int ADDR_W   = $clog2(SITES);

	// field widths
	localparam int RAND_W   = 16;
	localparam int LEVEL_W  = 16;
	localparam int MAG_W    = 10;
	localparam int ENERGY_W = 12;
	localparam int NB_W     = 3;
	localparam int CFG_IDX_W = 2;

	// running sums after reset: all spins +1
	localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITES);
	localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-4 * SITES);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DE4 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DE8 = CFG_IDX_W'(1);

	// neighborhood read order
	localparam logic [2:0] RD_CENTER = 3'd0;
	localparam logic [2:0] RD_UP     = 3'd1;
	localparam logic [2:0] RD_DOWN   = 3'd2;
	localparam logic [2:0] RD_LEFT   = 3'd3;
	localparam logic [2:0] RD_RIGHT  = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_UPDATE
	} state_t;

	// outcome of one metropolis trial
	typedef struct packed {
		logic              flip;
		logic              new_spin;
		logic signed [2:0] dmag;
		logic signed [6:0] denergy;
	} decision_t;

endpackage

`default_nettype wire

FILE: rtl/ismu_spin_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ismu_spin_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 1,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/ismu_decide.sv
// metropolis acceptance test for one site from its spin and neighbor count
// depends on ismu_pkg
`default_nettype none

module ismu_decide import ismu_pkg::*; (
	input  wire logic              center,
	input  wire logic [NB_W-1:0]   nb_up_cnt,
	input  wire logic [RAND_W-1:0] rand_val,
	input  wire logic [LEVEL_W-1:0] level_de4,
	input  wire logic [LEVEL_W-1:0] level_de8,
	output decision_t              dec
);

	logic [NB_W-1:0]   agree;
	logic signed [6:0] de2;
	logic              flip;

	// neighbors that match the site spin; dE = 4*agree - 8
	assign agree = center ? nb_up_cnt : NB_W'(3'd4 - nb_up_cnt);

	// energy change on flip is 2*dE = 8*agree - 16
	assign de2 = $signed({1'b0, agree, 3'b000}) - 7'sd16;

	// downhill and flat moves always accepted, uphill against the configured level
	always_comb begin
		priority if (agree <= NB_W'(2)) begin
			flip = 1'b1;
		end else if (agree == NB_W'(3)) begin
			flip = rand_val < RAND_W'(level_de4);
		end else begin
			flip = rand_val < RAND_W'(level_de8);
		end
	end

	always_comb begin
		dec.flip     = flip;
		dec.new_spin = center ^ flip;
		dec.dmag     = center ? -3'sd2 : 3'sd2;
		dec.denergy  = de2;
	end

endmodule

`default_nettype wire

FILE: rtl/ising_metropolis_spin_update_unit.sv
// Ising metropolis spin update unit, top level: sequencer, spin memory and sums
// depends on ismu_pkg, ismu_spin_ram, ismu_decide
// One request at a time: a new one is taken only in the idle state, after the
// result of the last has been loaded into the output register; the five reads of the
// neighborhood go through the single read port of the spin memory.
// Reset: a clearing pass writes +1 to each of the 256 sites; in_stall
// stays high during it. Configuration writes are taken at any time.
`default_nettype none

module ising_metropolis_spin_update_unit import ismu_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [3:0]                 row,
	input  wire logic [3:0]                 col,
	input  wire logic [RAND_W-1:0]          random_value,
	// output channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            flipped,
	output logic                            spin_after,
	output logic signed [MAG_W-1:0]         magnet_sum,
	output logic signed [ENERGY_W-1:0]      energy_sum,
	// configuration channel
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [LEVEL_W-1:0]         cfg_data
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0]  clr_cnt_q;
	logic [2:0]         rd_cnt_q;
	logic               rd_pend_s1;
	logic [2:0]         rd_idx_s1;
	logic [COORD_W-1:0] row_q, col_q;
	logic [RAND_W-1:0]  rand_q;
	logic               center_q;
	logic [NB_W-1:0]    nb_cnt_q;
	logic [LEVEL_W-1:0] level_de4_q, level_de8_q;
	logic signed [MAG_W-1:0]    magnet_q;
	logic signed [ENERGY_W-1:0] energy_q;
	logic               out_valid_q, flipped_q, spin_after_q;

	logic               in_fire, out_free, do_update, ram_we, ram_wdata, ram_rdata;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [COORD_W-1:0] rd_row, rd_col;
	decision_t          dec;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port control
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		do_update = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = {row_q, col_q};
		ram_wdata = dec.new_spin;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = 1'b1;
				if (clr_cnt_q == ADDR_W'(SITES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (rd_cnt_q == RD_RIGHT) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free) begin
					do_update = 1'b1;
					ram_we    = dec.flip;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// neighbor address with periodic wrap
	always_comb begin
		rd_row = row_q;
		rd_col = col_q;
		unique case (rd_cnt_q)
			RD_UP:    rd_row = (row_q == '0) ? COORD_W'(SIDE - 1) : row_q - 1'b1;
			RD_DOWN:  rd_row = (row_q == COORD_W'(SIDE - 1)) ? '0 : row_q + 1'b1;
			RD_LEFT:  rd_col = (col_q == '0) ? COORD_W'(SIDE - 1) : col_q - 1'b1;
			RD_RIGHT: rd_col = (col_q == COORD_W'(SIDE - 1)) ? '0 : col_q + 1'b1;
			default: begin
				rd_row = row_q;
				rd_col = col_q;
			end
		endcase
	end
	assign ram_raddr = {rd_row, rd_col};

	ismu_spin_ram #(
		.DEPTH(SITES),
		.WIDTH(1)
	) u_spin_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ismu_decide u_decide (
		.center   (center_q),
		.nb_up_cnt(nb_cnt_q),
		.rand_val (rand_q),
		.level_de4(level_de4_q),
		.level_de8(level_de8_q),
		.dec      (dec)
	);

	// clearing pass and read sequence counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			rd_cnt_q   <= '0;
			rd_pend_s1 <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (in_fire) begin
				rd_cnt_q <= RD_CENTER;
			end else if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			rd_pend_s1 <= (state_q == ST_READ);
			rd_idx_s1  <= rd_cnt_q;
		end
	end

	// request capture and neighborhood gather
	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_q    <= row;
			col_q    <= col;
			rand_q   <= random_value;
			nb_cnt_q <= '0;
		end else if (rd_pend_s1) begin
			if (rd_idx_s1 == RD_CENTER) begin
				center_q <= ram_rdata;
			end else begin
				nb_cnt_q <= nb_cnt_q + NB_W'(ram_rdata);
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_de4_q <= '0;
			level_de8_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_LEVEL_DE4) begin
				level_de4_q <= cfg_data;
			end
			if (cfg_index == CFG_LEVEL_DE8) begin
				level_de8_q <= cfg_data;
			end
		end
	end

	// running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magnet_q <= MAG_RESET;
			energy_q <= ENERGY_RESET;
		end else if (do_update && dec.flip) begin
			magnet_q <= magnet_q + MAG_W'(dec.dmag);
			energy_q <= energy_q + ENERGY_W'(dec.denergy);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_update) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_update) begin
			flipped_q    <= dec.flip;
			spin_after_q <= dec.new_spin;
		end
	end

	assign out_valid  = out_valid_q;
	assign flipped    = flipped_q;
	assign spin_after = spin_after_q;
	assign magnet_sum = magnet_q;
	assign energy_sum = energy_q;

	// a result appears only from the update step
	a_out_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UPDATE))
		else $error("result raised outside update step");

	// an accepted request starts the neighborhood read at the center
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_READ && rd_cnt_q == RD_CENTER))
		else $error("accepted request did not start read sequence");

	// magnetization changes in steps of two from an even start
	a_magnet_even: assert property (@(posedge clk) disable iff (!arst_n)
		magnet_q[0] == 1'b0)
		else $error("odd magnetization sum");

	// energy changes in steps of eight from a multiple of eight
	a_energy_step: assert property (@(posedge clk) disable iff (!arst_n)
		energy_q[2:0] == 3'b000)
		else $error("energy sum not a multiple of eight");

	// memory is written only while clearing or on an update
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || do_update))
		else $error("spin memory write outside clear or update");

endmodule

`default_nettype wire

FILE: tb/ismu_spin_checker.sv
// result checker for the ising metropolis spin update unit: keeps its own lattice,
// predicts every trial and compares it with the block's result requests
// depends on ismu_pkg
`timescale 1ns / 100ps

module ismu_spin_checker import ismu_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [3:0]                  row,
	input  logic [3:0]                  col,
	input  logic [RAND_W-1:0]           random_value,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        flipped,
	input  logic                        spin_after,
	input  logic signed [MAG_W-1:0]     magnet_sum,
	input  logic signed [ENERGY_W-1:0]  energy_sum,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [LEVEL_W-1:0]          cfg_data,
	output int                          mismatches,
	output int                          outstanding
);

	typedef struct packed {
		logic                       flipped;
		logic                       spin_after;
		logic signed [MAG_W-1:0]    magnet;
		logic signed [ENERGY_W-1:0] energy;
	} trial_result_t;

	// shadow copy of the lattice, the running sums and the levels
	logic               spins [SITES];
	int                 magnet_total;
	int                 energy_total;
	logic [LEVEL_W-1:0] level_de4;
	logic [LEVEL_W-1:0] level_de8;
	trial_result_t      pending_results [$];
	int                 fail_count;

	assign mismatches = fail_count;

	// spin at a site as +1 or -1
	function int spin_at(input int r, input int c);
		return spins[r * SIDE + c] ? 1 : -1;
	endfunction

	task automatic log_mismatch(input string field, input int want_v, input int got_v);
		if (fail_count < 10)
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, field,
				want_v, got_v);
		fail_count++;
	endtask

	// watch all three channels; predict on input requests, compare on result requests
	always @(posedge clk or negedge arst_n) begin : watch
		trial_result_t want;
		int            r;
		int            c;
		int            s;
		int            nb;
		int            de;
		logic          take;
		if (!arst_n) begin
			for (int i = 0; i < SITES; i++)
				spins[i] = 1'b1;
			magnet_total = SITES;
			energy_total = -4 * SITES;
			level_de4    = '0;
			level_de8    = '0;
			pending_results.delete();
			fail_count   = 0;
			outstanding <= 0;
		end else begin
			// level writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LEVEL_DE4: level_de4 = cfg_data;
					CFG_LEVEL_DE8: level_de8 = cfg_data;
					default: ;
				endcase
			end

			// metropolis trial at the requested site, periodic wrap
			if (in_valid && !in_stall) begin
				r  = int'(row) % SIDE;
				c  = int'(col) % SIDE;
				s  = spin_at(r, c);
				nb = spin_at((r + 1) % SIDE, c) + spin_at((r + SIDE - 1) % SIDE, c)
					+ spin_at(r, (c + SIDE - 1) % SIDE) + spin_at(r, (c + 1) % SIDE);
				de = 2 * s * nb;
				if (de <= 0)
					take = 1'b1;
				else if (de == 4)
					take = random_value < level_de4;
				else
					take = random_value < level_de8;
				if (take) begin
					spins[r * SIDE + c] = ~spins[r * SIDE + c];
					magnet_total -= 2 * s;
					energy_total += 2 * de;
				end
				want.flipped    = take;
				want.spin_after = spins[r * SIDE + c];
				want.magnet     = MAG_W'(magnet_total);
				want.energy     = ENERGY_W'(energy_total);
				pending_results.insert(pending_results.size(), want);
			end

			// compare against the oldest prediction
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					if (fail_count < 10)
						$display("%0t ns: result request with no trial pending", $realtime);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (want.flipped !== flipped)
						log_mismatch("flipped", want.flipped, flipped);
					if (want.spin_after !== spin_after)
						log_mismatch("spin_after", want.spin_after, spin_after);
					if (want.magnet !== magnet_sum)
						log_mismatch("magnet_sum", want.magnet, magnet_sum);
					if (want.energy !== energy_sum)
						log_mismatch("energy_sum", want.energy, energy_sum);
				end
			end

			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// top of the spin update testbench: clock, reset, stimulus and verdict
// depends on ismu_pkg, ising_metropolis_spin_update_unit and ismu_spin_checker
`timescale 1ns / 100ps

module testbench;
	import ismu_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);
	localparam int DRAIN_CYCLES = 16;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic [3:0]                 row          = '0;
	logic [3:0]                 col          = '0;
	logic [RAND_W-1:0]          random_value = '0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic                       flipped;
	logic                       spin_after;
	logic signed [MAG_W-1:0]    magnet_sum;
	logic signed [ENERGY_W-1:0] energy_sum;
	logic                       cfg_valid    = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index    = '0;
	logic [LEVEL_W-1:0]         cfg_data     = '0;

	int                 mismatches;
	int                 outstanding;
	logic               tx_quiet = 1'b0;
	logic               rx_quiet = 1'b0;
	int                 stall_left = 0;
	int                 stall_draw;
	logic [LEVEL_W-1:0] level4_now = '0;
	logic [LEVEL_W-1:0] level8_now = '0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	ising_metropolis_spin_update_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row          (row),
		.col          (col),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.flipped      (flipped),
		.spin_after   (spin_after),
		.magnet_sum   (magnet_sum),
		.energy_sum   (energy_sum),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	ismu_spin_checker spin_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row          (row),
		.col          (col),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.flipped      (flipped),
		.spin_after   (spin_after),
		.magnet_sum   (magnet_sum),
		.energy_sum   (energy_sum),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// result side: after each accepted result, out_stall may be raised at random unless rx_quiet is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			stall_draw = rx_quiet ? 0 : $urandom_range(0, 7);
			stall_left <= stall_draw;
			out_stall  <= (stall_draw != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end
	end

	// one trial request, after a random gap
	task automatic send_trial(input logic [3:0] r, input logic [3:0] c,
		input logic [RAND_W-1:0] u);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		row          <= r;
		col          <= c;
		random_value <= u;
		do @(posedge clk); while (in_stall);
	endtask

	// register write; cfg_valid stays high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_levels(input logic [LEVEL_W-1:0] de4, input logic [LEVEL_W-1:0] de8);
		write_reg(CFG_LEVEL_DE4, de4);
		write_reg(CFG_LEVEL_DE8, de8);
		cfg_valid  <= 1'b0;
		level4_now = de4;
		level8_now = de8;
	endtask

	// hold off new trials until every result has come back, then let the pipe settle
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [3:0]        cur_row;
		logic [3:0]        cur_col;
		logic [RAND_W-1:0] u;
		int                phase;
		int                n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unused indexes, then zero levels: nothing uphill is ever taken
		write_reg(CFG_SPARE_2, LEVEL_W'($urandom));
		write_reg(CFG_SPARE_3, LEVEL_W'($urandom));
		set_levels('0, '0);
		tx_quiet = 1'b1;
		send_trial(4'd5, 4'd5, 16'h0000);
		send_trial(4'd5, 4'd5, 16'hFFFF);
		wait_for_results();

		// levels at maximum: u of all ones still rejected, downhill and flat moves
		set_levels(16'hFFFF, 16'hFFFF);
		send_trial(4'd0, 4'd0, 16'hFFFF);
		send_trial(4'd0, 4'd0, 16'hFFFE);
		send_trial(4'd0, 4'd1, 16'h0000);
		send_trial(4'd0, 4'd0, 16'h1234);
		send_trial(4'd15, 4'd15, 16'h0000);
		send_trial(4'd15, 4'd15, 16'hFFFF);
		send_trial(4'd0, 4'd15, 16'h8000);
		send_trial(4'd15, 4'd0, 16'h0000);
		send_trial(4'd3, 4'd3, 16'h0000);
		send_trial(4'd3, 4'd5, 16'h0000);
		send_trial(4'd3, 4'd4, 16'hFFFF);
		send_trial(4'd7, 4'd7, 16'h0000);
		send_trial(4'd7, 4'd8, 16'hFFFF);
		wait_for_results();

		// u equal to the level is rejected, one below is taken
		set_levels(16'h4000, 16'h2000);
		send_trial(4'd10, 4'd10, 16'h2000);
		send_trial(4'd10, 4'd10, 16'h1FFF);
		send_trial(4'd10, 4'd11, 16'h4000);
		send_trial(4'd10, 4'd11, 16'h3FFF);
		wait_for_results();

		// random phases, each at its own temperature
		cur_row = 4'd0;
		cur_col = 4'd0;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_levels(16'hFFFF, 16'hFFFF);
				1: set_levels(LEVEL_W'($urandom), LEVEL_W'($urandom));
				2: set_levels('0, '0);
				3: set_levels(16'h8000, 16'h1000);
				4: set_levels(LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom));
				default: set_levels(LEVEL_W'($urandom), LEVEL_W'($urandom_range(0, 4095)));
			endcase
			tx_quiet = (phase == 1);
			rx_quiet <= (phase == 1 || phase == 4);
			for (n = 0; n < 67; n++) begin
				// half the trials hit the last site or a neighbor of it
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 4))
						0: ;
						1: cur_row = cur_row - 4'd1;
						2: cur_row = cur_row + 4'd1;
						3: cur_col = cur_col - 4'd1;
						default: cur_col = cur_col + 4'd1;
					endcase
				end else begin
					cur_row = 4'($urandom);
					cur_col = 4'($urandom);
				end
				case ($urandom_range(0, 9))
					0: u = '0;
					1: u = '1;
					2: u = level4_now;
					3: u = level4_now - 16'd1;
					4: u = level8_now;
					5: u = level8_now - 16'd1;
					default: u = RAND_W'($urandom);
				endcase
				send_trial(cur_row, cur_col, u);
			end
			wait_for_results();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hard limit on run time
	initial begin : watchdog
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
